@@ rtl/hsvh_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvh_pkg
// Shared types, constants and binning helpers for the HSV block histogram.
// ----------------------------------------------------------------------------
package hsvh_pkg;

  // payload widths
  localparam int CountW = 17;
  localparam int FracW  = 17;
  localparam int IdxW   = 6;

  // default histogram size and block pixel limit
  localparam int MaxBinBitsDef  = 6;
  localparam int MaxBlockPixels = 65536;
  localparam int CountLimitInt  = (MaxBlockPixels < 131071) ? MaxBlockPixels : 131071;
  localparam logic [CountW-1:0] CountLimit = CountW'(CountLimitInt);

  // channel full-scale values
  localparam logic [7:0] HueFull  = 8'd180;
  localparam logic [7:0] ChanFull = 8'd255;

  // register file
  localparam int PAddrW = 4;
  localparam int PDataW = 32;
  localparam logic [1:0] REG_HUE_BITS = 2'd0;
  localparam logic [1:0] REG_SAT_BITS = 2'd1;
  localparam logic [1:0] REG_VAL_BITS = 2'd2;
  localparam logic [1:0] BitsReset    = 2'd2;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_RD,
    ST_LOAD,
    ST_DIV
  } hist_state_t;

  // clamp a bin-bit setting to 2 and to the bits still left in the budget
  function automatic logic [1:0] eff_bits(logic [1:0] raw, logic [2:0] budget);
    logic [1:0] c;
    c = (raw > 2'd2) ? 2'd2 : raw;
    if ({1'b0, c} > budget) c = budget[1:0];
    return c;
  endfunction

  // min(floor(x * 2^bits / full), 2^bits - 1) by threshold compares
  function automatic logic [1:0] chan_bin(logic [7:0] x, logic [1:0] bits,
                                          logic [7:0] full);
    logic [9:0] xs;
    logic [9:0] thr;
    logic [1:0] b;
    xs = {2'b00, x} << bits;
    b  = 2'd0;
    for (int k = 1; k < 4; k++) begin
      thr = 10'(k) * {2'b00, full};
      if ((k < (1 << bits)) && (xs >= thr)) b = 2'(k);
    end
    return b;
  endfunction

endpackage

@@ rtl/hsvh_ram.sv @@
// ----------------------------------------------------------------------------
// hsvh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsvh_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/hsvh_div.sv @@
// ----------------------------------------------------------------------------
// hsvh_div
// Radix-2 restoring divider: (count << 16) / total, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hsvh_div
  import hsvh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CountW-1:0] count,
  input  logic [CountW-1:0] total,
  output logic              done,
  output logic [FracW-1:0]  quot
);

  localparam int StepW = $clog2(FracW + 1);

  logic [StepW-1:0]  steps;
  logic [CountW-1:0] rem;
  logic [CountW-1:0] sh;
  logic [CountW-1:0] divisor;
  logic [CountW:0]   trial;
  logic              fits;

  // shift in the next dividend bit and test against the divisor
  assign trial = {rem, sh[CountW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // control: step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= StepW'(FracW);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - StepW'(1);
      if (steps == StepW'(1)) done <= 1'b1;
    end
  end

  // datapath; count never exceeds total, so count >> 1 starts below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= {1'b0, count[CountW-1:1]};
      sh      <= {count[0], {(CountW-1){1'b0}}};
      divisor <= total;
      quot    <= '0;
    end else if (steps != '0) begin
      rem  <= fits ? CountW'(trial - {1'b0, divisor}) : trial[CountW-1:0];
      sh   <= {sh[CountW-2:0], 1'b0};
      quot <= {quot[FracW-2:0], fits};
    end
  end

endmodule

@@ rtl/hsv_block_histogram_unit.sv @@
// A pixel's count is written in the cycle after it is accepted; pixels enter one per cycle
// while the unit is accumulating. After the last pixel of a block the input stalls while
// the histogram drains: a flush state, then for each bin a memory read, a load of the
// bit-serial divider and the division; the drain waits while the bin output is stalled.
// Reset: synchronous; clears bin valid bits and pixel total, and sets the bin-bit registers to 2.
// ----------------------------------------------------------------------------
// hsv_block_histogram_unit
// 3-D HSV histogram of one pixel block, drained as count and fraction per bin.
// ----------------------------------------------------------------------------
module hsv_block_histogram_unit
  import hsvh_pkg::*;
#(
  parameter int MAX_BIN_BITS = MaxBinBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  // pixel channel
  input  logic              pix_valid,
  output logic              pix_stall,
  input  logic [7:0]        hue,
  input  logic [7:0]        sat,
  input  logic [7:0]        val,
  input  logic              last_pixel,
  // bin channel
  output logic              bin_valid,
  input  logic              bin_stall,
  output logic [IdxW-1:0]   bin_index,
  output logic [FracW-1:0]  bin_fraction,
  output logic [CountW-1:0] bin_count,
  output logic              last_bin,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  localparam int Depth = 1 << MAX_BIN_BITS;
  localparam int BinAw = $clog2(Depth);
  localparam logic [2:0] BitBudget = 3'(MAX_BIN_BITS);

  logic [1:0]        hue_bits, sat_bits, val_bits;
  logic [1:0]        hb, sb, vb;
  logic [2:0]        tot_bits;
  logic [6:0]        last_idx_w;
  logic [BinAw-1:0]  last_idx;
  logic [IdxW-1:0]   pix_idx_w;
  logic [BinAw-1:0]  pix_idx;
  logic              pix_acc;
  logic              cfg_wr;

  hist_state_t       state, state_next;
  logic              s1_valid;
  logic [BinAw-1:0]  s1_idx;
  logic              fw_valid;
  logic [BinAw-1:0]  fw_idx;
  logic [CountW-1:0] fw_data;
  logic [Depth-1:0]  slot_used;
  logic [CountW-1:0] pixel_total;
  logic [CountW-1:0] old_count, new_count;
  logic [BinAw-1:0]  drain_idx;
  logic [CountW-1:0] drain_count;
  logic [CountW-1:0] load_count;
  logic              drain_last;
  logic              out_load;
  logic              block_clear;

  logic              ram_re;
  logic [BinAw-1:0]  ram_raddr;
  logic [CountW-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [FracW-1:0]  div_quot;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_bits <= BitsReset;
      sat_bits <= BitsReset;
      val_bits <= BitsReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HUE_BITS: hue_bits <= pwdata[1:0];
        REG_SAT_BITS: sat_bits <= pwdata[1:0];
        REG_VAL_BITS: val_bits <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE_BITS: prdata = {{(PDataW-2){1'b0}}, hue_bits};
      REG_SAT_BITS: prdata = {{(PDataW-2){1'b0}}, sat_bits};
      REG_VAL_BITS: prdata = {{(PDataW-2){1'b0}}, val_bits};
      default:      prdata = '0;
    endcase
  end

  // effective bin layout under the bit budget
  assign hb         = eff_bits(hue_bits, BitBudget);
  assign sb         = eff_bits(sat_bits, BitBudget - {1'b0, hb});
  assign vb         = eff_bits(val_bits, BitBudget - {1'b0, hb} - {1'b0, sb});
  assign tot_bits   = {1'b0, hb} + {1'b0, sb} + {1'b0, vb};
  assign last_idx_w = (7'd1 << tot_bits) - 7'd1;
  assign last_idx   = last_idx_w[BinAw-1:0];

  // packed bin number of the incoming pixel
  assign pix_idx_w = ({4'b0000, chan_bin(val, vb, ChanFull)} << ({1'b0, hb} + {1'b0, sb}))
                   | ({4'b0000, chan_bin(sat, sb, ChanFull)} << hb)
                   |  {4'b0000, chan_bin(hue, hb, HueFull)};
  assign pix_idx   = pix_idx_w[BinAw-1:0];

  assign pix_stall = (state != ST_ACCUM);
  assign pix_acc   = pix_valid & ~pix_stall;

  // bin count memory
  assign ram_re    = pix_acc | (state == ST_RD);
  assign ram_raddr = (state == ST_RD) ? drain_idx : pix_idx;

  hsvh_ram #(
    .WIDTH (CountW),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_idx),
    .wdata (new_count),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read-modify-write stage, forwarding the write issued at the read edge
  always_comb begin
    if (fw_valid && (fw_idx == s1_idx)) begin
      old_count = fw_data;
    end else if (slot_used[s1_idx]) begin
      old_count = ram_rdata;
    end else begin
      old_count = '0;
    end
    new_count = (old_count < CountLimit) ? old_count + CountW'(1) : old_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= pix_acc;
      fw_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= pix_idx;
    fw_idx  <= s1_idx;
    fw_data <= new_count;
  end

  // slot valid bits and pixel total
  always_ff @(posedge clk) begin
    if (rst || block_clear) begin
      slot_used   <= '0;
      pixel_total <= '0;
    end else begin
      if (s1_valid) slot_used[s1_idx] <= 1'b1;
      if (pix_acc && (pixel_total < CountLimit)) pixel_total <= pixel_total + CountW'(1);
    end
  end

  // drain datapath
  assign load_count = slot_used[drain_idx] ? ram_rdata : '0;
  assign div_start  = (state == ST_LOAD);
  assign drain_last = (drain_idx == last_idx);

  hsvh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (load_count),
    .total (pixel_total),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (div_start) drain_count <= load_count;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACCUM;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    out_load    = 1'b0;
    block_clear = 1'b0;
    case (state)
      ST_ACCUM: begin
        if (pix_acc && last_pixel) state_next = ST_FLUSH;
      end
      ST_FLUSH: state_next = ST_RD;
      ST_RD:    state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done && (!bin_valid || !bin_stall)) begin
          out_load    = 1'b1;
          block_clear = drain_last;
          state_next  = drain_last ? ST_ACCUM : ST_RD;
        end
      end
      default:  state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_idx <= '0;
    end else if (out_load) begin
      drain_idx <= drain_last ? '0 : drain_idx + BinAw'(1);
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else if (out_load) begin
      bin_valid <= 1'b1;
    end else if (!bin_stall) begin
      bin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_index    <= IdxW'(drain_idx);
      bin_fraction <= div_quot;
      bin_count    <= drain_count;
      last_bin     <= drain_last;
    end
  end

endmodule

@@ rtl/hsvh_checker.sv @@
// ----------------------------------------------------------------------------
// hsvh_checker
// Port-level checks for the HSV block histogram, bound to the top level.
// ----------------------------------------------------------------------------
module hsvh_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_stall,
  input logic        last_pixel,
  input logic        bin_valid,
  input logic        bin_stall,
  input logic [5:0]  bin_index,
  input logic [16:0] bin_fraction,
  input logic [16:0] bin_count,
  input logic        last_bin
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    bin_valid && bin_stall |=> bin_valid && $stable(bin_index)
      && $stable(bin_fraction) && $stable(bin_count) && $stable(last_bin))
    else $error("stalled bin item changed");

  // the last pixel of a block starts the drain, which stalls the pixel side
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && last_pixel |=> pix_stall)
    else $error("pixel side not stalled after last pixel");

  // an empty bin has a zero fraction
  a_empty_bin: assert property (@(posedge clk) disable iff (rst)
    bin_valid && (bin_count == 17'd0) |-> (bin_fraction == 17'd0))
    else $error("empty bin with nonzero fraction");

  // a fraction never exceeds one
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    bin_valid |-> (bin_fraction <= 17'd65536))
    else $error("bin fraction above one");

endmodule

bind hsv_block_histogram_unit hsvh_checker u_chk (.*);
